/* src/fprt_pkg.sv */
package fprt_pkg;

	localparam int NumChannelsDef = 6;
	localparam int CustomBytes = 8;
	localparam int PresetCount = 15;
	localparam int QueueDepth = 2;
	localparam int QueuePtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QueueCntW = $clog2(QueueDepth + 1);

	localparam logic [3:0] KIND_CUSTOM = 4'd0;
	localparam logic [3:0] KIND_FREQ_LO = 4'd1;
	localparam logic [3:0] KIND_FREQ_HI = 4'd2;
	localparam logic [3:0] KIND_PATCH = 4'd3;

	localparam logic [2:0] RELOAD_LAST_STEP = 3'd5;
	localparam logic [7:0] FREQ_LO_BASE = 8'hA0;
	localparam logic [7:0] FREQ_HI_BASE = 8'hB0;

	typedef struct packed {
		logic [7:0] reg_addr;
		logic [7:0] write_value;
	} req_t;

	typedef struct packed {
		logic [7:0] first_address;
		logic [7:0] first_data;
		logic [7:0] second_address;
		logic [7:0] second_data;
		logic       second_valid;
		logic       last_item;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_CUSTOM,
		OP_FREQ_LO,
		OP_FREQ_HI,
		OP_PATCH
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [3:0] idx;
		logic [7:0] value;
	} cmd_t;

	typedef logic [7:0][7:0] patch_t;

	localparam logic [7:0] PresetRom [0:PresetCount-1][0:CustomBytes-1] = '{
		'{8'h03, 8'h01, 8'h14, 8'h80, 8'hC2, 8'h90, 8'h43, 8'h14},
		'{8'h13, 8'h41, 8'h10, 8'h0B, 8'hFF, 8'hF2, 8'h32, 8'hD6},
		'{8'h01, 8'h01, 8'h10, 8'h08, 8'hF0, 8'hF4, 8'h00, 8'h04},
		'{8'h21, 8'h41, 8'h1B, 8'h08, 8'h66, 8'h80, 8'h30, 8'h85},
		'{8'h22, 8'h21, 8'h20, 8'h03, 8'h75, 8'h70, 8'h24, 8'h14},
		'{8'h02, 8'h01, 8'h06, 8'h00, 8'hF0, 8'hF2, 8'h03, 8'h95},
		'{8'h21, 8'h41, 8'h18, 8'h10, 8'h93, 8'hE0, 8'h21, 8'h15},
		'{8'h01, 8'h22, 8'h13, 8'h00, 8'hF0, 8'h82, 8'h00, 8'h15},
		'{8'h05, 8'h01, 8'h22, 8'h00, 8'h60, 8'hE3, 8'hA0, 8'hF5},
		'{8'h85, 8'h01, 8'h20, 8'h00, 8'hD7, 8'hA2, 8'h22, 8'hF5},
		'{8'h07, 8'h81, 8'h2B, 8'h05, 8'hF4, 8'hF2, 8'h14, 8'hF4},
		'{8'h21, 8'h41, 8'h20, 8'h18, 8'hF3, 8'h80, 8'h13, 8'h95},
		'{8'h01, 8'h02, 8'h20, 8'h00, 8'hF9, 8'h92, 8'h41, 8'h75},
		'{8'h21, 8'h62, 8'h0E, 8'h00, 8'h84, 8'h85, 8'h45, 8'h15},
		'{8'h21, 8'h62, 8'h0E, 8'h00, 8'hA1, 8'hA0, 8'h34, 8'h16}
	};

	// Patch number 0 is the custom patch; 1 to 15 come from the preset table.
	function automatic patch_t select_patch(logic [3:0] sel, patch_t custom);
		patch_t     p;
		logic [3:0] row;
		row = sel - 4'd1;
		p = custom;
		if (sel != 4'd0) begin
			for (int b = 0; b < CustomBytes; b++) begin
				p[b] = PresetRom[row][b];
			end
		end
		return p;
	endfunction

	function automatic logic [7:0] slot_offset(logic [2:0] ch);
		logic [7:0] s;
		unique case (ch)
			3'd0: s = 8'h00;
			3'd1: s = 8'h01;
			3'd2: s = 8'h02;
			3'd3: s = 8'h08;
			3'd4: s = 8'h09;
			3'd5: s = 8'h0A;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

	// One of the eleven writes of a channel reload, as {address, data}.
	// Write number eleven does not exist and comes back as zero.
	function automatic logic [15:0] reload_write(logic [3:0] w, logic [2:0] ch,
			logic [7:0] pv, patch_t p);
		logic [7:0] s;
		logic [15:0] r;
		s = slot_offset(ch);
		unique case (w)
			4'd0:  r = {8'h20 + s, p[0]};
			4'd1:  r = {8'h23 + s, p[1]};
			4'd2:  r = {8'h40 + s, p[2]};
			4'd3:  r = {8'h43 + s, p[3][7:6], pv[3:0], 2'b00};
			4'd4:  r = {8'hE0 + s, 7'd0, p[3][3]};
			4'd5:  r = {8'hE3 + s, 7'd0, p[3][4]};
			4'd6:  r = {8'hC0 + {5'd0, ch}, 4'd0, p[3][2:0], 1'b0};
			4'd7:  r = {8'h60 + s, p[4]};
			4'd8:  r = {8'h63 + s, p[5]};
			4'd9:  r = {8'h80 + s, p[6]};
			4'd10: r = {8'h83 + s, p[7]};
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

/* src/fprt_front.sv */
module fprt_front #(
	parameter int NumChannels = fprt_pkg::NumChannelsDef
) (
	input  fprt_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output fprt_pkg::cmd_t cmd,
	output logic           cmd_push,
	input  logic           queue_full
);

	logic [3:0] kind;
	logic [3:0] idx;
	logic       keep;

	assign kind = req.reg_addr[7:4];
	assign idx = req.reg_addr[3:0];

	// Writes that cause nothing are taken and dropped here.
	always_comb begin
		cmd.idx = idx;
		cmd.value = req.write_value;
		cmd.op = fprt_pkg::OP_CUSTOM;
		keep = 1'b0;
		unique case (kind)
			fprt_pkg::KIND_CUSTOM: begin
				cmd.op = fprt_pkg::OP_CUSTOM;
				keep = idx < 4'(fprt_pkg::CustomBytes);
			end
			fprt_pkg::KIND_FREQ_LO: begin
				cmd.op = fprt_pkg::OP_FREQ_LO;
				keep = idx < 4'(NumChannels);
			end
			fprt_pkg::KIND_FREQ_HI: begin
				cmd.op = fprt_pkg::OP_FREQ_HI;
				keep = idx < 4'(NumChannels);
			end
			fprt_pkg::KIND_PATCH: begin
				cmd.op = fprt_pkg::OP_PATCH;
				keep = idx < 4'(NumChannels);
			end
			default: keep = 1'b0;
		endcase
	end

	assign req_stall = queue_full;
	assign cmd_push = req_valid && !queue_full && keep;

endmodule

/* src/fprt_queue.sv */
module fprt_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  fprt_pkg::cmd_t push_cmd,
	input  logic           push,
	output logic           full,
	output fprt_pkg::cmd_t pop_cmd,
	output logic           pop_valid,
	input  logic           pop
);

	fprt_pkg::cmd_t                    entry_q [fprt_pkg::QueueDepth];
	logic [fprt_pkg::QueuePtrW-1:0]    wr_ptr_q;
	logic [fprt_pkg::QueuePtrW-1:0]    rd_ptr_q;
	logic [fprt_pkg::QueueCntW-1:0]    count_q;

	assign full = count_q == fprt_pkg::QueueCntW'(fprt_pkg::QueueDepth);
	assign pop_valid = count_q != '0;
	assign pop_cmd = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == fprt_pkg::QueuePtrW'(fprt_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == fprt_pkg::QueuePtrW'(fprt_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* src/fprt_back.sv */
module fprt_back #(
	parameter int NumChannels = fprt_pkg::NumChannelsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fprt_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	output fprt_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);

	localparam int ChIdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

	typedef enum logic {
		S_IDLE,
		S_EMIT
	} state_t;

	state_t            state_q;
	fprt_pkg::op_t     op_q;
	logic [ChIdxW-1:0] ch_q;
	logic [2:0]        step_q;
	fprt_pkg::patch_t  custom_q;
	logic [7:0]        freq_lo_q [NumChannels];
	logic [7:0]        freq_hi_q [NumChannels];
	logic [7:0]        pv_q [NumChannels];
	fprt_pkg::rsp_t    rsp_q;
	logic              rsp_valid_q;

	logic              advance;
	logic [2:0]        ch3;
	logic [7:0]        ch_addr;
	logic [7:0]        high_word;
	logic [7:0]        cur_pv;
	fprt_pkg::patch_t  patch;
	logic [3:0]        w0;
	logic [15:0]       wr0;
	logic [15:0]       wr1;
	logic [ChIdxW-1:0] first_listen;
	logic              any_listen;
	logic [ChIdxW-1:0] next_listen;
	logic              more_listen;
	logic              last_step;
	fprt_pkg::rsp_t    item;

	assign advance = !rsp_valid_q || !rsp_stall;
	assign cmd_pop = (state_q == S_IDLE) && cmd_valid;
	assign rsp = rsp_q;
	assign rsp_valid = rsp_valid_q;

	// Channels on the custom patch: the first one, and the next one after ch_q.
	always_comb begin
		first_listen = '0;
		any_listen = 1'b0;
		next_listen = '0;
		more_listen = 1'b0;
		for (int c = NumChannels - 1; c >= 0; c--) begin
			if (pv_q[c][7:4] == 4'd0) begin
				first_listen = ChIdxW'(c);
				any_listen = 1'b1;
				if (c > int'(ch_q)) begin
					next_listen = ChIdxW'(c);
					more_listen = 1'b1;
				end
			end
		end
	end

	assign ch3 = 3'(ch_q);
	assign ch_addr = {5'd0, ch3};
	assign high_word = {2'b00, freq_hi_q[ch_q][4:0], freq_lo_q[ch_q][7]};
	assign cur_pv = pv_q[ch_q];
	assign patch = fprt_pkg::select_patch(cur_pv[7:4], custom_q);
	assign w0 = {step_q, 1'b0};
	assign wr0 = fprt_pkg::reload_write(w0, ch3, cur_pv, patch);
	assign wr1 = fprt_pkg::reload_write(w0 + 4'd1, ch3, cur_pv, patch);
	assign last_step = step_q == fprt_pkg::RELOAD_LAST_STEP;

	always_comb begin
		item = '0;
		unique case (op_q)
			fprt_pkg::OP_FREQ_LO: begin
				item.first_address = fprt_pkg::FREQ_LO_BASE + ch_addr;
				item.first_data = {freq_lo_q[ch_q][6:0], 1'b0};
				item.second_address = fprt_pkg::FREQ_HI_BASE + ch_addr;
				item.second_data = high_word;
				item.second_valid = 1'b1;
				item.last_item = 1'b1;
			end
			fprt_pkg::OP_FREQ_HI: begin
				item.first_address = fprt_pkg::FREQ_HI_BASE + ch_addr;
				item.first_data = high_word;
				item.last_item = 1'b1;
			end
			fprt_pkg::OP_CUSTOM, fprt_pkg::OP_PATCH: begin
				item.first_address = wr0[15:8];
				item.first_data = wr0[7:0];
				item.second_address = wr1[15:8];
				item.second_data = wr1[7:0];
				item.second_valid = !last_step;
				item.last_item = last_step &&
					((op_q == fprt_pkg::OP_PATCH) || !more_listen);
			end
			default: item = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q <= fprt_pkg::OP_CUSTOM;
			ch_q <= '0;
			step_q <= '0;
			custom_q <= '0;
			for (int c = 0; c < NumChannels; c++) begin
				freq_lo_q[c] <= '0;
				freq_hi_q[c] <= '0;
				pv_q[c] <= '0;
			end
			rsp_q <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_EMIT) && advance) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						op_q <= cmd.op;
						step_q <= '0;
						unique case (cmd.op)
							fprt_pkg::OP_CUSTOM: begin
								custom_q[cmd.idx[2:0]] <= cmd.value;
								ch_q <= first_listen;
								// A custom byte with no channel on patch 0 is only stored.
								if (any_listen) begin
									state_q <= S_EMIT;
								end
							end
							fprt_pkg::OP_FREQ_LO: begin
								ch_q <= cmd.idx[ChIdxW-1:0];
								freq_lo_q[cmd.idx[ChIdxW-1:0]] <= cmd.value;
								state_q <= S_EMIT;
							end
							fprt_pkg::OP_FREQ_HI: begin
								ch_q <= cmd.idx[ChIdxW-1:0];
								freq_hi_q[cmd.idx[ChIdxW-1:0]] <= cmd.value;
								state_q <= S_EMIT;
							end
							fprt_pkg::OP_PATCH: begin
								ch_q <= cmd.idx[ChIdxW-1:0];
								pv_q[cmd.idx[ChIdxW-1:0]] <= cmd.value;
								state_q <= S_EMIT;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_EMIT: begin
					if (advance) begin
						rsp_q <= item;
						if (item.last_item) begin
							state_q <= S_IDLE;
						end else if (last_step) begin
							step_q <= '0;
							ch_q <= next_listen;
						end else begin
							step_q <= step_q + 3'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* src/fm_patch_register_translator_core.sv */
// Register write translator for a two-operator FM synthesizer.
// The req channel takes one source register write (reg_addr, write_value)
// per item; the rsp channel gives the resulting target writes, up to two to an
// item, with last_item set on the final item caused by each write.
// A frequency low write gives one item, a frequency high write one item,
// an instrument/volume write six items, and a custom patch byte six items
// for every channel that uses the custom patch (up to 36). Writes to
// unknown or out-of-range registers are taken and give nothing.
// A write passes the queue, the back end's idle state and the output register
// before its first result item. The back end sends one item per cycle while
// rsp is not stalled; it takes each write from the queue in its idle state and
// takes no new write before the previous write's last item is in the output register.
// A two-entry queue sits between decode and the back end; req_stall rises
// only when that queue is full. A stall on rsp holds the output item
// steady and stops the back end, which in turn fills the queue.
// Reset clears all channel and custom patch registers to zero and empties
// the queue and the output register.
module fm_patch_register_translator_core #(
	parameter int NumChannels = fprt_pkg::NumChannelsDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fprt_pkg::req_t req,
	input  logic           req_valid,
	output logic           req_stall,
	output fprt_pkg::rsp_t rsp,
	output logic           rsp_valid,
	input  logic           rsp_stall
);

	fprt_pkg::cmd_t push_cmd;
	fprt_pkg::cmd_t pop_cmd;
	logic           push;
	logic           full;
	logic           pop_valid;
	logic           pop;

	fprt_front #(
		.NumChannels(NumChannels)
	) u_front (
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (push_cmd),
		.cmd_push  (push),
		.queue_full(full)
	);

	fprt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_cmd (push_cmd),
		.push     (push),
		.full     (full),
		.pop_cmd  (pop_cmd),
		.pop_valid(pop_valid),
		.pop      (pop)
	);

	fprt_back #(
		.NumChannels(NumChannels)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (pop_cmd),
		.cmd_valid(pop_valid),
		.cmd_pop  (pop),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall)
	);

endmodule

/* verif/fm_patch_register_translator_core_test.sv */
`timescale 1ns / 1ps

module fm_patch_register_translator_core_test;

	localparam int NUM_CH = fprt_pkg::NumChannelsDef;

	// Preset instrument table, patch numbers 1 to 15.
	localparam logic [7:0] PRESET_PATCH [15][8] = '{
		'{8'h03, 8'h01, 8'h14, 8'h80, 8'hC2, 8'h90, 8'h43, 8'h14},
		'{8'h13, 8'h41, 8'h10, 8'h0B, 8'hFF, 8'hF2, 8'h32, 8'hD6},
		'{8'h01, 8'h01, 8'h10, 8'h08, 8'hF0, 8'hF4, 8'h00, 8'h04},
		'{8'h21, 8'h41, 8'h1B, 8'h08, 8'h66, 8'h80, 8'h30, 8'h85},
		'{8'h22, 8'h21, 8'h20, 8'h03, 8'h75, 8'h70, 8'h24, 8'h14},
		'{8'h02, 8'h01, 8'h06, 8'h00, 8'hF0, 8'hF2, 8'h03, 8'h95},
		'{8'h21, 8'h41, 8'h18, 8'h10, 8'h93, 8'hE0, 8'h21, 8'h15},
		'{8'h01, 8'h22, 8'h13, 8'h00, 8'hF0, 8'h82, 8'h00, 8'h15},
		'{8'h05, 8'h01, 8'h22, 8'h00, 8'h60, 8'hE3, 8'hA0, 8'hF5},
		'{8'h85, 8'h01, 8'h20, 8'h00, 8'hD7, 8'hA2, 8'h22, 8'hF5},
		'{8'h07, 8'h81, 8'h2B, 8'h05, 8'hF4, 8'hF2, 8'h14, 8'hF4},
		'{8'h21, 8'h41, 8'h20, 8'h18, 8'hF3, 8'h80, 8'h13, 8'h95},
		'{8'h01, 8'h02, 8'h20, 8'h00, 8'hF9, 8'h92, 8'h41, 8'h75},
		'{8'h21, 8'h62, 8'h0E, 8'h00, 8'h84, 8'h85, 8'h45, 8'h15},
		'{8'h21, 8'h62, 8'h0E, 8'h00, 8'hA1, 8'hA0, 8'h34, 8'h16}
	};

	localparam logic [7:0] SLOT_BASE [6] = '{8'h00, 8'h01, 8'h02, 8'h08, 8'h09, 8'h0A};

	logic clk = 1'b0;
	logic arst_n;
	fprt_pkg::req_t req;
	logic req_valid;
	logic req_stall;
	fprt_pkg::rsp_t rsp;
	logic rsp_valid;
	logic rsp_stall;

	// Shadow of the block's register file.
	logic [7:0] custom_patch [8] = '{default: 8'h00};
	logic [7:0] freq_low [6] = '{default: 8'h00};
	logic [7:0] freq_high_block [6] = '{default: 8'h00};
	logic [7:0] patch_vol [6] = '{default: 8'h00};

	fprt_pkg::rsp_t target_write_q [$];
	int mismatch_count = 0;

	bit send_gaps = 1'b1;
	bit rsp_gaps = 1'b1;
	int hold_off_len = 0;

	fm_patch_register_translator_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Target writes are packed two to an item; an odd one out rides alone.
	function automatic void queue_writes(input logic [7:0] adr [11],
			input logic [7:0] dat [11], input int n);
		fprt_pkg::rsp_t r;
		for (int i = 0; i < n; i += 2) begin
			r = '0;
			r.first_address = adr[i];
			r.first_data = dat[i];
			if (i + 1 < n) begin
				r.second_address = adr[i + 1];
				r.second_data = dat[i + 1];
				r.second_valid = 1'b1;
			end
			target_write_q.push_back(r);
		end
	endfunction

	function automatic void queue_reload(input int ch);
		logic [7:0] adr [11];
		logic [7:0] dat [11];
		logic [7:0] p [8];
		logic [7:0] pv;
		logic [7:0] s;
		pv = patch_vol[ch];
		s = SLOT_BASE[ch];
		for (int b = 0; b < 8; b++) begin
			p[b] = (pv[7:4] == 4'd0) ? custom_patch[b] : PRESET_PATCH[pv[7:4] - 4'd1][b];
		end
		adr[0] = 8'h20 + s;   dat[0] = p[0];
		adr[1] = 8'h23 + s;   dat[1] = p[1];
		adr[2] = 8'h40 + s;   dat[2] = p[2];
		adr[3] = 8'h43 + s;   dat[3] = {p[3][7:6], pv[3:0], 2'b00};
		adr[4] = 8'hE0 + s;   dat[4] = {7'd0, p[3][3]};
		adr[5] = 8'hE3 + s;   dat[5] = {7'd0, p[3][4]};
		adr[6] = 8'hC0 + 8'(ch); dat[6] = {4'd0, p[3][2:0], 1'b0};
		adr[7] = 8'h60 + s;   dat[7] = p[4];
		adr[8] = 8'h63 + s;   dat[8] = p[5];
		adr[9] = 8'h80 + s;   dat[9] = p[6];
		adr[10] = 8'h83 + s;  dat[10] = p[7];
		queue_writes(adr, dat, 11);
	endfunction

	function automatic logic [7:0] block_word(input int ch);
		return {2'b00, freq_high_block[ch][4:0], freq_low[ch][7]};
	endfunction

	// Updates the shadow registers and queues the target writes one source write causes.
	function automatic void translate_write(input fprt_pkg::req_t w);
		logic [3:0] kind;
		logic [3:0] idx;
		logic [7:0] adr [11];
		logic [7:0] dat [11];
		int prior_size;
		fprt_pkg::rsp_t r;
		kind = w.reg_addr[7:4];
		idx = w.reg_addr[3:0];
		prior_size = target_write_q.size();
		adr = '{default: 8'h00};
		dat = '{default: 8'h00};
		case (kind)
			fprt_pkg::KIND_CUSTOM: begin
				if (idx < fprt_pkg::CustomBytes) begin
					custom_patch[idx[2:0]] = w.write_value;
					for (int ch = 0; ch < NUM_CH; ch++) begin
						if (patch_vol[ch][7:4] == 4'd0)
							queue_reload(ch);
					end
				end
			end
			fprt_pkg::KIND_FREQ_LO: begin
				if (idx < NUM_CH) begin
					freq_low[idx] = w.write_value;
					adr[0] = fprt_pkg::FREQ_LO_BASE + 8'(idx);
					dat[0] = {w.write_value[6:0], 1'b0};
					adr[1] = fprt_pkg::FREQ_HI_BASE + 8'(idx);
					dat[1] = block_word(idx);
					queue_writes(adr, dat, 2);
				end
			end
			fprt_pkg::KIND_FREQ_HI: begin
				if (idx < NUM_CH) begin
					freq_high_block[idx] = w.write_value;
					adr[0] = fprt_pkg::FREQ_HI_BASE + 8'(idx);
					dat[0] = block_word(idx);
					queue_writes(adr, dat, 1);
				end
			end
			fprt_pkg::KIND_PATCH: begin
				if (idx < NUM_CH) begin
					patch_vol[idx] = w.write_value;
					queue_reload(idx);
				end
			end
			default: ;
		endcase
		if (target_write_q.size() > prior_size) begin
			r = target_write_q.pop_back();
			r.last_item = 1'b1;
			target_write_q.push_back(r);
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			translate_write(req);
	end

	always @(posedge clk) begin
		fprt_pkg::rsp_t exp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (target_write_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("%0t: unexpected item %h/%h %h/%h sv=%b last=%b", $realtime,
						rsp.first_address, rsp.first_data, rsp.second_address,
						rsp.second_data, rsp.second_valid, rsp.last_item);
			end else begin
				exp = target_write_q.pop_front();
				if (rsp !== exp) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"%0t: expected %h/%h %h/%h sv=%b last=%b,",
							" got %h/%h %h/%h sv=%b last=%b"}, $realtime,
							exp.first_address, exp.first_data, exp.second_address,
							exp.second_data, exp.second_valid, exp.last_item,
							rsp.first_address, rsp.first_data, rsp.second_address,
							rsp.second_data, rsp.second_valid, rsp.last_item);
				end
			end
		end
	end

	// Receiver: random stall bursts, or one long hold-off when a test asks for it.
	initial begin
		int n;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				n = hold_off_len;
				hold_off_len = 0;
				rsp_stall <= 1'b1;
				repeat (n) @(posedge clk);
				rsp_stall <= 1'b0;
			end else if (rsp_gaps && $urandom_range(0, 7) == 0) begin
				rsp_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// Called at a rising edge; returns at the edge where the item is taken.
	task automatic send_write(input fprt_pkg::req_t w);
		if (send_gaps && $urandom_range(0, 4) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
	endtask

	// Mostly well-formed writes; a few land anywhere in the address space.
	function automatic fprt_pkg::req_t random_write();
		fprt_pkg::req_t w;
		int pick;
		pick = $urandom_range(0, 99);
		w.write_value = 8'($urandom);
		if (pick < 12) begin
			w.reg_addr = {fprt_pkg::KIND_CUSTOM,
				4'($urandom_range(0, fprt_pkg::CustomBytes - 1))};
		end else if (pick < 42) begin
			w.reg_addr = {fprt_pkg::KIND_FREQ_LO, 4'($urandom_range(0, NUM_CH - 1))};
		end else if (pick < 67) begin
			w.reg_addr = {fprt_pkg::KIND_FREQ_HI, 4'($urandom_range(0, NUM_CH - 1))};
		end else if (pick < 90) begin
			w.reg_addr = {fprt_pkg::KIND_PATCH, 4'($urandom_range(0, NUM_CH - 1))};
			// Keep a fair number of channels on the custom patch so its writes fan out.
			if ($urandom_range(0, 2) == 0)
				w.write_value[7:4] = 4'd0;
		end else begin
			w.reg_addr = 8'($urandom);
		end
		return w;
	endfunction

	task automatic test_directed();
		logic [15:0] seq [22] = '{
			// A custom byte straight after reset reloads all six channels.
			16'h03A5,
			16'h10FF, 16'h1500, 16'h20FF, 16'h253C,
			16'h300F, 16'h35FF, 16'h321A,
			16'h00FF, 16'h0700,
			// Custom index, channel and kind out of range: all ignored.
			16'h0855, 16'h0FAA, 16'h1612, 16'h3F12, 16'h4000, 16'hFFFF,
			// Move every channel off the custom patch, then write a custom byte
			// that nobody listens to.
			16'h3020, 16'h3130, 16'h3340, 16'h3450, 16'h0477,
			16'h3108
		};
		foreach (seq[i])
			send_write(fprt_pkg::req_t'(seq[i]));
	endtask

	task automatic test_random(input int count);
		repeat (count)
			send_write(random_write());
	endtask

	// The receiver holds off while writes keep coming, so the queue fills and
	// req_stall must rise.
	task automatic test_backpressure();
		fprt_pkg::req_t w;
		send_gaps = 1'b0;
		hold_off_len = 150;
		repeat (8) begin
			w.reg_addr = {fprt_pkg::KIND_PATCH, 4'($urandom_range(0, NUM_CH - 1))};
			w.write_value = 8'($urandom);
			send_write(w);
		end
		send_gaps = 1'b1;
	endtask

	task automatic test_steady_stream(input int count);
		send_gaps = 1'b0;
		rsp_gaps = 1'b0;
		test_random(count);
	endtask

	initial begin
		arst_n <= 1'b0;
		req <= '0;
		req_valid <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random(300);
		test_backpressure();
		test_steady_stream(80);

		req_valid <= 1'b0;
		while (target_write_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (target_write_q.size() != 0) begin
			mismatch_count++;
			$display("%0d expected items never arrived", target_write_q.size());
		end
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("timeout, %0d items still expected", target_write_q.size());
		$display("== FAIL ==");
		$finish;
	end

endmodule
